// ----- sv/acsq_pkg.sv -----
// ----------------------------------------------------------------------------
// acsq_pkg
// Shared types and constants for the adc channel scan sequencer.
// ----------------------------------------------------------------------------
package acsq_pkg;

  // channel count default and field widths
  localparam int NUM_CHANNELS_DEF = 3;
  localparam int CH_W    = 2;
  localparam int SMP_W   = 12;
  localparam int TIME_W  = 32;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // bus error pattern for a read byte
  localparam logic [7:0] READ_ERR_BYTE = 8'hFF;

  // config register reset values
  localparam logic [7:0] WAIT_MS_RST     = 8'd2;
  localparam logic [3:0] MAX_RETRIES_RST = 4'd10;
  localparam logic [2:0] GAIN_CODE_RST   = 3'd5;
  localparam logic [2:0] RATE_CODE_RST   = 3'd4;

  // config register indexes
  typedef enum logic [1:0] {
    REG_WAIT_MS     = 2'd0,
    REG_MAX_RETRIES = 2'd1,
    REG_GAIN_CODE   = 2'd2,
    REG_RATE_CODE   = 2'd3
  } reg_idx_t;

  // result action codes
  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_START   = 2'd1,
    ACT_REQUEST = 2'd2,
    ACT_RETRY   = 2'd3
  } action_t;

  // scan phases, one-hot
  typedef enum logic [4:0] {
    PH_INIT        = 5'b00001,
    PH_SAMPLE_NEXT = 5'b00010,
    PH_WAIT        = 5'b00100,
    PH_READ_RESULT = 5'b01000,
    PH_STORE       = 5'b10000
  } phase_t;

  // configuration register set
  typedef struct packed {
    logic [7:0] wait_ms;
    logic [3:0] max_retries;
    logic [2:0] gain_code;
    logic [2:0] rate_code;
  } cfg_t;

  // one input item
  typedef struct packed {
    logic              bus_done;
    logic [7:0]        read_high;
    logic [7:0]        read_low;
    logic [TIME_W-1:0] now_ms;
    logic [CH_W-1:0]   query_channel;
  } in_item_t;

  // one result item
  typedef struct packed {
    action_t                  action;
    logic [CH_W-1:0]          conv_channel;
    logic [7:0]               cfg_high;
    logic [7:0]               cfg_low;
    logic                     stored_valid;
    logic [CH_W-1:0]          stored_channel;
    logic signed [SMP_W-1:0]  stored_value;
    logic                     fault;
    logic signed [SMP_W-1:0]  query_value;
  } out_item_t;

endpackage

// ----- sv/acsq_if.sv -----
// ----------------------------------------------------------------------------
// acsq channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface acsq_in_if;
  logic                             valid;
  logic                             ready;
  logic                             bus_done;
  logic [7:0]                       read_high;
  logic [7:0]                       read_low;
  logic [acsq_pkg::TIME_W-1:0]      now_ms;
  logic [acsq_pkg::CH_W-1:0]        query_channel;

  modport source (output valid, bus_done, read_high, read_low, now_ms, query_channel,
                  input ready);
  modport sink   (input valid, bus_done, read_high, read_low, now_ms, query_channel,
                  output ready);
endinterface

interface acsq_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       action;
  logic [acsq_pkg::CH_W-1:0]        conv_channel;
  logic [7:0]                       cfg_high;
  logic [7:0]                       cfg_low;
  logic                             stored_valid;
  logic [acsq_pkg::CH_W-1:0]        stored_channel;
  logic signed [acsq_pkg::SMP_W-1:0] stored_value;
  logic                             fault;
  logic signed [acsq_pkg::SMP_W-1:0] query_value;

  modport source (output valid, action, conv_channel, cfg_high, cfg_low, stored_valid,
                  stored_channel, stored_value, fault, query_value,
                  input ready);
  modport sink   (input valid, action, conv_channel, cfg_high, cfg_low, stored_valid,
                  stored_channel, stored_value, fault, query_value,
                  output ready);
endinterface

// ----- sv/adc_channel_scan_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// adc_channel_scan_sequencer_top
// Round-robin scan sequencer for an external 12-bit ADC.
// ----------------------------------------------------------------------------
//  port group   dir   role
//  in_ch        in    update item: bus state, read bytes, time, query
//  out_ch       out   result item: action, config bytes, stored sample, fault
//  psel..pready cfg   register access, 4 registers at byte address 4*i
//
//  An item is held in the input register, is evaluated, and its result is
//  loaded into the output register. One item per cycle sustained while the
//  output is not stalled; the scan state updates as the item leaves the input
//  register, so the next item sees it right away.
//  A stalled output holds its result; the input register still takes one item.
//  Synchronous active-low reset clears state, config and the sample store.
// ----------------------------------------------------------------------------
module adc_channel_scan_sequencer_top #(
  parameter int NUM_CHANNELS = acsq_pkg::NUM_CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  acsq_in_if.sink                     in_ch,
  acsq_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [acsq_pkg::ADDR_W-1:0] paddr,
  input  logic [acsq_pkg::DATA_W-1:0] pwdata,
  output logic [acsq_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  acsq_pkg::cfg_t      cfg;
  acsq_pkg::in_item_t  in_item_r;
  acsq_pkg::out_item_t res;
  acsq_pkg::out_item_t out_item_r;
  logic                in_valid_r;
  logic                out_valid_r;
  logic                adv;
  logic                fire;

  // pipeline flow
  assign adv         = !out_valid_r || out_ch.ready;
  assign fire        = in_valid_r && adv;
  assign in_ch.ready = !in_valid_r || adv;

  // configuration registers
  acsq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.bus_done      <= in_ch.bus_done;
      in_item_r.read_high     <= in_ch.read_high;
      in_item_r.read_low      <= in_ch.read_low;
      in_item_r.now_ms        <= in_ch.now_ms;
      in_item_r.query_channel <= in_ch.query_channel;
    end
  end

  // scan logic
  acsq_core #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_item_r <= res;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.action         = out_item_r.action;
  assign out_ch.conv_channel   = out_item_r.conv_channel;
  assign out_ch.cfg_high       = out_item_r.cfg_high;
  assign out_ch.cfg_low        = out_item_r.cfg_low;
  assign out_ch.stored_valid   = out_item_r.stored_valid;
  assign out_ch.stored_channel = out_item_r.stored_channel;
  assign out_ch.stored_value   = out_item_r.stored_value;
  assign out_ch.fault          = out_item_r.fault;
  assign out_ch.query_value    = out_item_r.query_value;

endmodule

// ----- sv/acsq_cfg.sv -----
// ----------------------------------------------------------------------------
// acsq_cfg
// APB-style configuration registers with read back.
// ----------------------------------------------------------------------------
module acsq_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [acsq_pkg::ADDR_W-1:0] paddr,
  input  logic [acsq_pkg::DATA_W-1:0] pwdata,
  output logic [acsq_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output acsq_pkg::cfg_t              cfg
);

  acsq_pkg::cfg_t     cfg_r;
  acsq_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = acsq_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wait_ms     <= acsq_pkg::WAIT_MS_RST;
      cfg_r.max_retries <= acsq_pkg::MAX_RETRIES_RST;
      cfg_r.gain_code   <= acsq_pkg::GAIN_CODE_RST;
      cfg_r.rate_code   <= acsq_pkg::RATE_CODE_RST;
    end else if (wr_en) begin
      unique case (idx)
        acsq_pkg::REG_WAIT_MS:     cfg_r.wait_ms     <= pwdata[7:0];
        acsq_pkg::REG_MAX_RETRIES: cfg_r.max_retries <= pwdata[3:0];
        acsq_pkg::REG_GAIN_CODE:   cfg_r.gain_code   <= pwdata[2:0];
        acsq_pkg::REG_RATE_CODE:   cfg_r.rate_code   <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    unique case (idx)
      acsq_pkg::REG_WAIT_MS:     prdata[7:0] = cfg_r.wait_ms;
      acsq_pkg::REG_MAX_RETRIES: prdata[3:0] = cfg_r.max_retries;
      acsq_pkg::REG_GAIN_CODE:   prdata[2:0] = cfg_r.gain_code;
      acsq_pkg::REG_RATE_CODE:   prdata[2:0] = cfg_r.rate_code;
      default: prdata = '0;
    endcase
  end

endmodule

// ----- sv/acsq_core.sv -----
// ----------------------------------------------------------------------------
// acsq_core
// Scan state machine, retry counter and sample store; one item per fire.
// ----------------------------------------------------------------------------
module acsq_core #(
  parameter int NUM_CHANNELS = acsq_pkg::NUM_CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  acsq_pkg::in_item_t   item,
  input  acsq_pkg::cfg_t       cfg,
  output acsq_pkg::out_item_t  res
);

  localparam logic [acsq_pkg::CH_W-1:0] LAST_CH = acsq_pkg::CH_W'(NUM_CHANNELS - 1);

  acsq_pkg::phase_t                phase_r, phase_nxt;
  logic [acsq_pkg::CH_W-1:0]       scan_ch_r, scan_ch_nxt;
  logic [3:0]                      err_cnt_r, err_cnt_nxt;
  logic [acsq_pkg::TIME_W-1:0]     wait_start_r, wait_start_nxt;
  logic signed [acsq_pkg::SMP_W-1:0] store_r [NUM_CHANNELS];

  logic                            read_err;
  logic [acsq_pkg::TIME_W-1:0]     elapsed;
  logic                            wait_over;
  logic signed [acsq_pkg::SMP_W-1:0] sample;
  logic                            store_en;
  logic signed [acsq_pkg::SMP_W-1:0] query_val;

  assign read_err  = (item.read_high == acsq_pkg::READ_ERR_BYTE) &&
                     (item.read_low  == acsq_pkg::READ_ERR_BYTE);
  assign elapsed   = item.now_ms - wait_start_r;
  assign wait_over = elapsed > {{(acsq_pkg::TIME_W-8){1'b0}}, cfg.wait_ms};
  assign sample    = {item.read_high, item.read_low[7:4]};

  // step logic
  always_comb begin
    phase_nxt      = phase_r;
    scan_ch_nxt    = scan_ch_r;
    err_cnt_nxt    = err_cnt_r;
    wait_start_nxt = wait_start_r;
    store_en       = 1'b0;
    res            = '0;
    res.action     = acsq_pkg::ACT_NONE;
    if (item.bus_done) begin
      if (read_err) begin
        if (err_cnt_r < cfg.max_retries) begin
          res.action  = acsq_pkg::ACT_RETRY;
          err_cnt_nxt = err_cnt_r + 4'd1;
        end else begin
          res.fault = 1'b1;
        end
      end else begin
        err_cnt_nxt = '0;
        unique case (phase_r)
          acsq_pkg::PH_SAMPLE_NEXT: begin
            res.action       = acsq_pkg::ACT_START;
            res.conv_channel = scan_ch_r;
            res.cfg_high     = {1'b1, 3'(scan_ch_r) + 3'd1, cfg.gain_code, 1'b1};
            res.cfg_low      = {cfg.rate_code, 5'b00011};
            wait_start_nxt   = item.now_ms;
            phase_nxt        = acsq_pkg::PH_WAIT;
          end
          acsq_pkg::PH_WAIT: begin
            if (wait_over) phase_nxt = acsq_pkg::PH_READ_RESULT;
          end
          acsq_pkg::PH_READ_RESULT: begin
            res.action = acsq_pkg::ACT_REQUEST;
            phase_nxt  = acsq_pkg::PH_STORE;
          end
          acsq_pkg::PH_STORE: begin
            res.stored_valid   = 1'b1;
            res.stored_channel = scan_ch_r;
            res.stored_value   = sample;
            store_en           = 1'b1;
            scan_ch_nxt        = (scan_ch_r == LAST_CH) ? '0 : scan_ch_r + 1'b1;
            phase_nxt          = acsq_pkg::PH_SAMPLE_NEXT;
          end
          default: begin
            scan_ch_nxt = '0;
            phase_nxt   = acsq_pkg::PH_SAMPLE_NEXT;
          end
        endcase
      end
    end
    res.query_value = query_val;
  end

  // stored sample lookup, showing this item's write
  always_comb begin
    query_val = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (item.query_channel == acsq_pkg::CH_W'(i)) begin
        if (store_en && scan_ch_r == acsq_pkg::CH_W'(i)) query_val = sample;
        else                                               query_val = store_r[i];
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= acsq_pkg::PH_INIT;
      scan_ch_r    <= '0;
      err_cnt_r    <= '0;
      wait_start_r <= '0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      scan_ch_r    <= scan_ch_nxt;
      err_cnt_r    <= err_cnt_nxt;
      wait_start_r <= wait_start_nxt;
    end
  end

  // sample store, cleared by reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (!rst_n) begin
        store_r[i] <= '0;
      end else if (fire && store_en && scan_ch_r == acsq_pkg::CH_W'(i)) begin
        store_r[i] <= sample;
      end
    end
  end

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the adc channel scan sequencer. A behavioral model
// of the scan state machine predicts one result per accepted update item and
// every result is checked in order against it. Directed items cover the
// scan phases, timer wrap and retry/fault handling. Random traffic then runs
// over several register settings, with random gaps on both channels, a long
// output stall and a full drain in the middle of the traffic.
// ----------------------------------------------------------------------------
module tb;
  import acsq_pkg::*;

  localparam int NUM_CH      = NUM_CHANNELS_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SWEEP_ITEMS = 195;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  acsq_in_if  in_ch ();
  acsq_out_if out_ch ();

  adc_channel_scan_sequencer_top #(
    .NUM_CHANNELS(NUM_CH)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // scan model state and register copies
  logic [7:0]  wait_ms_q;
  logic [3:0]  retries_q;
  logic [2:0]  gain_q;
  logic [2:0]  rate_q;
  phase_t      phase_m;
  logic [1:0]  scan_ch_m;
  logic [3:0]  err_cnt_m;
  logic [31:0] wait_start_m;
  logic [11:0] samples_m [NUM_CH];

  out_item_t pending_results [$];
  int        fail_count;
  int        shown_count;
  int        cycle_count;

  // stimulus shaping
  bit          tx_idle;
  bit          rx_idle;
  int          hold_left;
  int          stall_left;
  int          burst_left;
  logic [31:0] now_cursor;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (shown_count < 10) begin
      shown_count++;
      $display("%s", msg);
    end
  endtask

  function automatic string show_result(input out_item_t r);
    return $sformatf("act=%0d conv=%0d cfg=%02h_%02h st=%0b/%0d/%0d fault=%0b query=%0d",
                     r.action, r.conv_channel, r.cfg_high, r.cfg_low, r.stored_valid,
                     r.stored_channel, r.stored_value, r.fault, r.query_value);
  endfunction

  // model reset
  task automatic reset_scan_model();
    wait_ms_q    = WAIT_MS_RST;
    retries_q    = MAX_RETRIES_RST;
    gain_q       = GAIN_CODE_RST;
    rate_q       = RATE_CODE_RST;
    phase_m      = PH_INIT;
    scan_ch_m    = '0;
    err_cnt_m    = '0;
    wait_start_m = '0;
    for (int i = 0; i < NUM_CH; i++) samples_m[i] = '0;
  endtask

  // one update of the scan state machine, returns its result item
  function automatic out_item_t scan_update(input in_item_t it);
    out_item_t   r;
    logic [31:0] elapsed;
    logic [11:0] sample;
    r = '0;
    r.action = ACT_NONE;
    if (it.bus_done) begin
      if (it.read_high == READ_ERR_BYTE && it.read_low == READ_ERR_BYTE) begin
        // bad read: retry while budget remains, else flag a fault
        if (err_cnt_m < retries_q) begin
          r.action  = ACT_RETRY;
          err_cnt_m = err_cnt_m + 4'd1;
        end else begin
          r.fault = 1'b1;
        end
      end else begin
        err_cnt_m = '0;
        case (phase_m)
          PH_SAMPLE_NEXT: begin
            r.action       = ACT_START;
            r.conv_channel = scan_ch_m;
            r.cfg_high     = {1'b1, {1'b0, scan_ch_m} + 3'd1, gain_q, 1'b1};
            r.cfg_low      = {rate_q, 5'b00011};
            wait_start_m   = it.now_ms;
            phase_m        = PH_WAIT;
          end
          PH_WAIT: begin
            elapsed = it.now_ms - wait_start_m;
            if (elapsed > {24'd0, wait_ms_q}) phase_m = PH_READ_RESULT;
          end
          PH_READ_RESULT: begin
            r.action = ACT_REQUEST;
            phase_m  = PH_STORE;
          end
          PH_STORE: begin
            sample             = {it.read_high, it.read_low[7:4]};
            r.stored_valid     = 1'b1;
            r.stored_channel   = scan_ch_m;
            r.stored_value     = sample;
            samples_m[scan_ch_m] = sample;
            scan_ch_m = (scan_ch_m == 2'(NUM_CH - 1)) ? 2'd0 : scan_ch_m + 2'd1;
            phase_m   = PH_SAMPLE_NEXT;
          end
          default: begin
            scan_ch_m = '0;
            phase_m   = PH_SAMPLE_NEXT;
          end
        endcase
      end
    end
    r.query_value = (it.query_channel < NUM_CH) ? samples_m[it.query_channel] : 12'd0;
    return r;
  endfunction

  function automatic in_item_t upd(input logic done, input logic [7:0] rh,
                                   input logic [7:0] rl, input logic [31:0] now,
                                   input logic [1:0] qch);
    in_item_t it;
    it.bus_done      = done;
    it.read_high     = rh;
    it.read_low      = rl;
    it.now_ms        = now;
    it.query_channel = qch;
    return it;
  endfunction

  // send one update item, predict its result on accept
  task automatic send_update(input in_item_t it);
    int gap;
    gap = tx_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.bus_done      <= it.bus_done;
    in_ch.read_high     <= it.read_high;
    in_ch.read_low      <= it.read_low;
    in_ch.now_ms        <= it.now_ms;
    in_ch.query_channel <= it.query_channel;
    in_ch.valid         <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(scan_update(it));
  endtask

  // stop sending and wait until every expected result has come
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one apb transfer: setup, then access, then idle
  task automatic apb_transfer(input bit wr, input reg_idx_t idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write a register with junk in the unused bits, then read it back
  task automatic set_reg(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] mask;
    logic [31:0] rdata;
    case (idx)
      REG_WAIT_MS:     mask = 32'hFF;
      REG_MAX_RETRIES: mask = 32'hF;
      default:         mask = 32'h7;
    endcase
    apb_transfer(1'b1, idx, ($urandom & ~mask) | (value & mask), rdata);
    case (idx)
      REG_WAIT_MS:     wait_ms_q = value[7:0];
      REG_MAX_RETRIES: retries_q = value[3:0];
      REG_GAIN_CODE:   gain_q    = value[2:0];
      default:         rate_q    = value[2:0];
    endcase
    apb_transfer(1'b0, idx, '0, rdata);
    if (rdata !== (value & mask))
      note_failure($sformatf("register %s read back %08h, expected %08h",
                             idx.name(), rdata, value & mask));
  endtask

  // random update with a time base that mostly lets the scan progress
  function automatic in_item_t make_update();
    in_item_t it;
    int       pick;
    int       rd;
    pick = $urandom_range(0, 99);
    rd   = $urandom_range(0, 99);
    it.query_channel = 2'($urandom_range(0, 3));
    it.bus_done      = ($urandom_range(0, 9) != 0);
    if (pick < 4)
      now_cursor = $urandom;
    else if (pick < 6)
      now_cursor = 32'hFFFF_FFFF - $urandom_range(0, 8);
    else if (pick < 14)
      now_cursor = wait_start_m + {24'd0, wait_ms_q} + (pick[0] ? 32'd1 : 32'd0);
    else
      now_cursor = now_cursor + $urandom_range(0, wait_ms_q / 4 + 3);
    it.now_ms = now_cursor;
    if (burst_left > 0) begin
      burst_left--;
      it.bus_done = 1'b1;
      {it.read_high, it.read_low} = 16'hFFFF;
    end else if (rd < 2) begin
      // run of bad reads, sometimes past the retry budget
      burst_left = $urandom_range(1, retries_q + 2);
      {it.read_high, it.read_low} = 16'hFFFF;
    end else if (rd < 6) begin
      {it.read_high, it.read_low} = 16'hFFFF;
    end else begin
      {it.read_high, it.read_low} = 16'($urandom);
    end
    return it;
  endfunction

  // random traffic; only updates with the bus finished count
  task automatic run_random(input int n);
    in_item_t it;
    int       done_count;
    done_count = 0;
    while (done_count < n) begin
      it = make_update();
      if (it.bus_done) done_count++;
      send_update(it);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.action         = action_t'(out_ch.action);
      got.conv_channel   = out_ch.conv_channel;
      got.cfg_high       = out_ch.cfg_high;
      got.cfg_low        = out_ch.cfg_low;
      got.stored_valid   = out_ch.stored_valid;
      got.stored_channel = out_ch.stored_channel;
      got.stored_value   = out_ch.stored_value;
      got.fault          = out_ch.fault;
      got.query_value    = out_ch.query_value;
      if (pending_results.size() == 0) begin
        note_failure($sformatf("result with nothing expected: %s", show_result(got)));
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          note_failure($sformatf("result mismatch\n  expected %s\n  actual   %s",
                                 show_result(want), show_result(got)));
      end
    end
  end

  // result receiver: random stall per item plus an optional long hold
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready)
      stall_left = rx_idle ? $urandom_range(0, 12) : 0;
    else if (stall_left > 0)
      stall_left--;
    if (hold_left > 0) hold_left--;
    out_ch.ready <= (stall_left == 0 && hold_left == 0);
  end

  // walk the scan once around with boundary times and sample values
  task automatic test_directed_scan();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_update(upd(1'b0, 8'hFF, 8'hFF, 32'd90, 2'd0));          // bus busy
    send_update(upd(1'b1, 8'h00, 8'h00, 32'd100, 2'd3));         // init
    send_update(upd(1'b1, 8'h00, 8'h00, 32'd100, 2'd3));         // start ch0
    send_update(upd(1'b1, 8'h12, 8'h34, 32'd102, 2'd0));         // elapsed equals wait
    send_update(upd(1'b1, 8'h12, 8'h34, 32'd103, 2'd0));         // elapsed past wait
    send_update(upd(1'b1, 8'hFF, 8'hFF, 32'd104, 2'd1));         // bad read, retry
    send_update(upd(1'b1, 8'h00, 8'h01, 32'd105, 2'd1));         // request
    send_update(upd(1'b1, 8'h7F, 8'hF0, 32'd106, 2'd0));         // store max positive
    send_update(upd(1'b1, 8'h00, 8'h00, 32'hFFFF_FFFE, 2'd0));   // start ch1
    send_update(upd(1'b1, 8'h00, 8'h00, 32'h0000_0001, 2'd1));   // wait across wrap
    send_update(upd(1'b1, 8'h00, 8'h00, 32'h0000_0002, 2'd1));   // request
    send_update(upd(1'b1, 8'h80, 8'h0F, 32'h0000_0003, 2'd1));   // store min negative
    send_update(upd(1'b1, 8'h00, 8'h00, 32'h0000_0000, 2'd2));   // start ch2
    send_update(upd(1'b1, 8'h00, 8'h00, 32'hFFFF_FFFF, 2'd2));   // huge elapsed
    send_update(upd(1'b1, 8'h00, 8'h00, 32'hFFFF_FFFF, 2'd2));   // request
    send_update(upd(1'b1, 8'hFF, 8'h00, 32'hFFFF_FFFF, 2'd2));   // high byte ff is a good read
    send_update(upd(1'b1, 8'h00, 8'h00, 32'd5, 2'd3));           // start wraps to ch0
  endtask

  // retry budget of zero and of two, fault on every bad read past it
  task automatic test_retry_and_fault();
    wait_drain();
    set_reg(REG_MAX_RETRIES, 32'd0);
    send_update(upd(1'b1, 8'hFF, 8'hFF, 32'd6, 2'd0));
    send_update(upd(1'b0, 8'hFF, 8'hFF, 32'd6, 2'd0));
    wait_drain();
    set_reg(REG_MAX_RETRIES, 32'd2);
    repeat (4) send_update(upd(1'b1, 8'hFF, 8'hFF, 32'd7, 2'd1));
    send_update(upd(1'b1, 8'hA5, 8'h5A, 32'd7, 2'd2));
    send_update(upd(1'b1, 8'hFF, 8'hFF, 32'd8, 2'd2));
  endtask

  // long output hold while items keep coming, then a full drain mid-stream
  task automatic test_backpressure();
    wait_drain();
    set_reg(REG_MAX_RETRIES, 32'd10);
    tx_idle   = 1'b0;
    rx_idle   = 1'b0;
    hold_left = 150;
    run_random(25);
    wait_drain();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    run_random(15);
  endtask

  // random traffic over several register settings, extremes included
  task automatic test_config_sweep();
    logic [7:0] w;
    logic [3:0] r;
    logic [2:0] g;
    logic [2:0] t;
    for (int k = 0; k < 6; k++) begin
      case (k)
        0: begin w = 8'd0;   r = 4'd0;  g = 3'd0; t = 3'd0; end
        1: begin w = 8'd255; r = 4'd15; g = 3'd7; t = 3'd7; end
        4: begin
          w = 8'($urandom_range(0, 255)); r = 4'($urandom); g = 3'($urandom);
          t = 3'($urandom);
        end
        default: begin
          w = 8'($urandom_range(0, 40)); r = 4'($urandom); g = 3'($urandom);
          t = 3'($urandom);
        end
      endcase
      wait_drain();
      set_reg(REG_WAIT_MS, {24'd0, w});
      set_reg(REG_MAX_RETRIES, {28'd0, r});
      set_reg(REG_GAIN_CODE, {29'd0, g});
      set_reg(REG_RATE_CODE, {29'd0, t});
      tx_idle = !(k == 2 || k == 5);
      rx_idle = !(k == 3 || k == 5);
      run_random(SWEEP_ITEMS);
    end
  endtask

  // main sequence
  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.bus_done      = 1'b0;
    in_ch.read_high     = '0;
    in_ch.read_low      = '0;
    in_ch.now_ms        = '0;
    in_ch.query_channel = '0;
    out_ch.ready        = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    fail_count          = 0;
    shown_count         = 0;
    cycle_count         = 0;
    hold_left           = 0;
    stall_left          = 0;
    burst_left          = 0;
    now_cursor          = 32'd200;
    tx_idle             = 1'b1;
    rx_idle             = 1'b1;
    reset_scan_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_scan();
    test_retry_and_fault();
    test_backpressure();
    test_config_sweep();

    wait_drain();
    repeat (8) @(posedge clk);
    fail_count += pending_results.size();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
